// ----- rtl/boxavg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boxavg_pkg
// Shared types, constants and the reciprocal table for the box average
// downsampler.
// ----------------------------------------------------------------------------
package boxavg_pkg;

  // Per-channel running sum in the line store (wraps at 24 bits)
  localparam int SUM_W        = 24;
  // Output height limit and row counter width
  localparam int HEIGHT_LIMIT = 4096;
  // Reciprocal scale: 2^24 / area, rounded up
  localparam int RECIP_W      = 25;
  localparam int RECIP_SHIFT  = 24;
  // Block area s*s, up to 15*15
  localparam int AREA_W       = 8;
  // Dividend width once the saturating case is split off (sum < 256*225)
  localparam int DIVIDEND_W   = 16;
  // Result queue
  localparam int FIFO_DEPTH   = 8;
  localparam int FIFO_AW      = 3;
  // Configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_index_t;

  typedef logic [2:0][SUM_W-1:0] sums_t;

  // Word handed from the line store to the divider
  typedef struct packed {
    sums_t sum;
    logic  last;
  } div_in_t;

  // One finished output pixel
  typedef struct packed {
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // ceil(2^24 / (s*s)) for s = 1..15; exact truncated quotient for
  // dividends below 256*s*s
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] s);
    logic [RECIP_W-1:0] m;
    unique case (s)
      4'd2:    m = 25'd4194304;
      4'd3:    m = 25'd1864136;
      4'd4:    m = 25'd1048576;
      4'd5:    m = 25'd671089;
      4'd6:    m = 25'd466034;
      4'd7:    m = 25'd342393;
      4'd8:    m = 25'd262144;
      4'd9:    m = 25'd207127;
      4'd10:   m = 25'd167773;
      4'd11:   m = 25'd138655;
      4'd12:   m = 25'd116509;
      4'd13:   m = 25'd99274;
      4'd14:   m = 25'd85599;
      4'd15:   m = 25'd74566;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/boxavg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boxavg_ram
// Simple dual-port RAM: one write port, one read port, registered read data,
// read-first on a same-address collision.
// ----------------------------------------------------------------------------
module boxavg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/boxavg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boxavg_div
// Two-stage divider: block sums divided by s*s through a reciprocal multiply,
// saturating at 255.
// ----------------------------------------------------------------------------
module boxavg_div
  import boxavg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  div_in_t            in_word,
  input  logic [AREA_W-1:0]  area,
  input  logic [RECIP_W-1:0] recip_m,
  output logic               out_valid,
  output pix_t               out_pix,
  output logic [1:0]         occupancy
);

  localparam int PROD_W = DIVIDEND_W + RECIP_W;

  // Stage 1: incoming sums
  logic  v1_r;
  sums_t sum1_r;
  logic  last1_r;

  // Stage 2: products and saturation flags
  logic                         v2_r;
  logic [2:0][PROD_W-1:0]       prod2_r;
  logic [2:0][PROD_W-1:0]       prod2_nxt;
  logic [2:0]                   sat2_r;
  logic [2:0]                   sat2_nxt;
  logic                         last2_r;
  logic [SUM_W-1:0]             thresh;
  logic [2:0][7:0]              q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sum1_r  <= in_word.sum;
    last1_r <= in_word.last;
    prod2_r <= prod2_nxt;
    sat2_r  <= sat2_nxt;
    last2_r <= last1_r;
  end

  // Anything at or above 256*area averages past 255
  assign thresh = SUM_W'({area, 8'h00});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat2_nxt[c]  = (sum1_r[c] >= thresh);
      prod2_nxt[c] = PROD_W'(sum1_r[c][DIVIDEND_W-1:0]) * PROD_W'(recip_m);
    end
  end

  // Quotient is the byte just above the reciprocal's fraction
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q[c] = sat2_r[c] ? 8'hFF : prod2_r[c][RECIP_SHIFT +: 8];
    end
  end

  assign out_valid      = v2_r;
  assign out_pix.red    = q[0];
  assign out_pix.green  = q[1];
  assign out_pix.blue   = q[2];
  assign out_pix.last   = last2_r;
  assign occupancy      = {1'b0, v1_r} + {1'b0, v2_r};

endmodule

// ----- rtl/box_average_downsampler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_downsampler
// Averages s-by-s blocks of an RGB sample stream into output pixels, keeping
// per-column running sums in a line store.
// ----------------------------------------------------------------------------
// Throughput: one sample per clock while the result queue has room, bounded by
// the line store's single read-modify-write per cycle (back-to-back hits on one
// column are forwarded). A block's last sample passes the line-store stage, both
// divider stages and the result queue before its output pixel can be taken.
// Reset: position counters clear, scale, width and height return to 1; the
// line store is not cleared and needs no clearing pass.
module box_average_downsampler
  import boxavg_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 8,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int SUB_W = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Sample stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // red [7:0], green [15:8], blue [23:16]
  // Output pixel stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // red [7:0], green [15:8], blue [23:16]
  output logic                  out_tlast   // frame_end
);

  localparam int ROW_W = $clog2(HEIGHT_LIMIT);

  // --------------------------------------------------------------------------
  // Configuration registers
  logic [3:0]  scale_r;
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [3:0]  s_eff;
  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [AREA_W-1:0]  area_r;
  logic [RECIP_W-1:0] recip_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= 4'd1;
      width_r  <= 11'd1;
      height_r <= 13'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SCALE:  scale_r  <= cfg_data[3:0];
        CFG_WIDTH:  width_r  <= cfg_data[10:0];
        CFG_HEIGHT: height_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversize values clamp
  always_comb begin
    priority if (scale_r == '0)             s_eff = 4'd1;
    else if (int'(scale_r) > MAX_FACTOR)    s_eff = 4'(MAX_FACTOR);
    else                                    s_eff = scale_r;
    priority if (width_r == '0)             w_eff = 11'd1;
    else if (int'(width_r) > MAX_WIDTH)     w_eff = 11'(MAX_WIDTH);
    else                                    w_eff = width_r;
    priority if (height_r == '0)            h_eff = 13'd1;
    else if (int'(height_r) > HEIGHT_LIMIT) h_eff = 13'(HEIGHT_LIMIT);
    else                                    h_eff = height_r;
  end

  // Divider constants, settled well before any item reaches the divider
  always_ff @(posedge clk) begin
    area_r  <= AREA_W'(s_eff) * AREA_W'(s_eff);
    recip_r <= recip(s_eff);
  end

  // --------------------------------------------------------------------------
  // Position counters
  logic [SUB_W-1:0] sub_col_r, sub_col_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [SUB_W-1:0] sub_row_r, sub_row_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic             in_accept;
  logic             col_end, row_end, ocol_end, orow_end;

  assign in_accept = in_tvalid && in_tready;
  assign col_end   = int'(sub_col_r) >= int'(s_eff) - 1;
  assign row_end   = int'(sub_row_r) >= int'(s_eff) - 1;
  assign ocol_end  = int'(out_col_r) >= int'(w_eff) - 1;
  assign orow_end  = int'(out_row_r) >= int'(h_eff) - 1;

  always_comb begin
    sub_col_nxt = sub_col_r;
    out_col_nxt = out_col_r;
    sub_row_nxt = sub_row_r;
    out_row_nxt = out_row_r;
    if (in_accept) begin
      if (!col_end) begin
        sub_col_nxt = sub_col_r + SUB_W'(1);
      end else begin
        sub_col_nxt = '0;
        if (!ocol_end) begin
          out_col_nxt = out_col_r + COL_W'(1);
        end else begin
          out_col_nxt = '0;
          if (!row_end) begin
            sub_row_nxt = sub_row_r + SUB_W'(1);
          end else begin
            sub_row_nxt = '0;
            out_row_nxt = orow_end ? '0 : out_row_r + ROW_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_col_r <= '0;
      out_col_r <= '0;
      sub_row_r <= '0;
      out_row_r <= '0;
    end else begin
      sub_col_r <= sub_col_nxt;
      out_col_r <= out_col_nxt;
      sub_row_r <= sub_row_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Line store read-modify-write stage
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  logic [2:0][7:0]  s1_px_r;
  logic             s1_first_r;
  logic             s1_emit_r;
  logic             s1_last_r;
  logic             fwd_hit_r;
  sums_t            fwd_sum_r;
  sums_t            rd_sum;
  sums_t            base_sum;
  sums_t            s1_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
      // Write of the item ahead lands on the same edge as this read
      fwd_hit_r  <= in_accept && s1_valid_r && (s1_col_r == out_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r   <= out_col_r;
      s1_px_r    <= in_tdata;
      s1_first_r <= (sub_row_r == '0) && (sub_col_r == '0);
      s1_emit_r  <= col_end && row_end;
      s1_last_r  <= ocol_end && orow_end;
    end
    fwd_sum_r <= s1_sum;
  end

  boxavg_ram #(
    .WIDTH (3 * SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (s1_sum),
    .re    (in_accept),
    .raddr (out_col_r),
    .rdata (rd_sum)
  );

  assign base_sum = fwd_hit_r ? fwd_sum_r : rd_sum;

  // First sample of a block overwrites, the rest accumulate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s1_sum[c] = s1_first_r ? SUM_W'(s1_px_r[c]) : base_sum[c] + SUM_W'(s1_px_r[c]);
    end
  end

  // --------------------------------------------------------------------------
  // Divider
  div_in_t    div_word;
  logic       div_valid;
  pix_t       div_pix;
  logic [1:0] div_occ;

  assign div_word.sum  = s1_sum;
  assign div_word.last = s1_last_r;

  boxavg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r && s1_emit_r),
    .in_word   (div_word),
    .area      (area_r),
    .recip_m   (recip_r),
    .out_valid (div_valid),
    .out_pix   (div_pix),
    .occupancy (div_occ)
  );

  // --------------------------------------------------------------------------
  // Result queue and input credit
  pix_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   fifo_cnt_r;
  logic               push, pop;
  logic [FIFO_AW+1:0] pending;

  assign push = div_valid;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      fifo_cnt_r <= fifo_cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_q[wr_ptr_r] <= div_pix;
  end

  // Every result that may still arrive has a slot reserved
  assign pending   = (FIFO_AW+2)'(fifo_cnt_r) + (FIFO_AW+2)'(div_occ)
                   + (FIFO_AW+2)'(s1_valid_r && s1_emit_r);
  assign in_tready = pending < (FIFO_AW+2)'(FIFO_DEPTH);

  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = {fifo_q[rd_ptr_r].blue, fifo_q[rd_ptr_r].green, fifo_q[rd_ptr_r].red};
  assign out_tlast  = fifo_q[rd_ptr_r].last;

  // --------------------------------------------------------------------------
  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_cnt_r != (FIFO_AW+1)'(FIFO_DEPTH)) || pop)
    else $error("result queue overflow");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending <= (FIFO_AW+2)'(FIFO_DEPTH))
    else $error("more results in flight than queue slots");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> s1_valid_r && $past(s1_valid_r))
    else $error("forwarding without a write ahead of it");

  a_fwd_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> s1_col_r == $past(s1_col_r))
    else $error("forwarded sum from another column");

endmodule

// ----- test/box_average_downsampler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_downsampler_tb
// Drives RGB sample frames through the downsampler at several block sizes and
// image shapes, predicts each averaged pixel and its frame-end flag alongside,
// and checks every pixel word that leaves the block, under varied back-pressure.
// ----------------------------------------------------------------------------
module box_average_downsampler_tb;
  import boxavg_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_FACTOR   = 8;
  localparam int RANDOM_ITEMS = 1150;
  // Give the pipeline room to empty before touching registers
  localparam int SETTLE_CYCLES = 8;
  // Overall run limit; leave plenty of margin
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 200;
  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // --------------------------------------------------------------------------
  // Running-sum predictor and the queue of pixels it still owes
  // --------------------------------------------------------------------------
  class pixel_average_book;
    logic [SUM_W-1:0]      band_sum [MAX_WIDTH][3];
    logic [3:0]            scale_reg;
    logic [10:0]           width_reg;
    logic [12:0]           height_reg;
    int unsigned           sub_col, out_col, sub_row, out_row;
    pix_t                  owed_pixels[$];
    int                    faults;

    function new();
      scale_reg  = 4'd1;
      width_reg  = 11'd1;
      height_reg = 13'd1;
      sub_col = 0;
      out_col = 0;
      sub_row = 0;
      out_row = 0;
      faults  = 0;
    endfunction

    function void note_fault(string what);
      faults++;
      if (faults <= 10) $display("%t: %s", $realtime, what);
    endfunction

    // zero acts as one, anything over the limit as the limit
    function int unsigned limit_reg(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SCALE:  scale_reg  = data[3:0];
        CFG_WIDTH:  width_reg  = data[10:0];
        CFG_HEIGHT: height_reg = data[12:0];
        default: ;
      endcase
    endfunction

    function bit idle();
      return owed_pixels.size() == 0;
    endfunction

    // One accepted sample word: update the column sum, maybe owe a pixel
    function void note_sample(logic [23:0] word);
      int unsigned s, w, h, col, area, avg;
      bit          col_end, row_end, ocol_end, orow_end;
      logic [7:0]  chan;
      pix_t        px;
      s = limit_reg(scale_reg, MAX_FACTOR);
      w = limit_reg(width_reg, MAX_WIDTH);
      h = limit_reg(height_reg, HEIGHT_LIMIT);
      col_end  = sub_col >= s - 1;
      row_end  = sub_row >= s - 1;
      ocol_end = out_col >= w - 1;
      orow_end = out_row >= h - 1;
      col = (out_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : out_col;
      area = s * s;
      px = '0;
      for (int c = 0; c < 3; c++) begin
        chan = word[8*c +: 8];
        if (sub_row == 0 && sub_col == 0) band_sum[col][c] = SUM_W'(chan);
        else band_sum[col][c] = band_sum[col][c] + SUM_W'(chan);
        avg = band_sum[col][c] / area;
        px[8*c +: 8] = (avg > 255) ? 8'd255 : avg[7:0];
      end
      px.last = ocol_end && orow_end;
      if (col_end && row_end) owed_pixels.push_back(px);

      // advance raster position
      if (!col_end) begin
        sub_col++;
      end else begin
        sub_col = 0;
        if (!ocol_end) begin
          out_col++;
        end else begin
          out_col = 0;
          if (!row_end) begin
            sub_row++;
          end else begin
            sub_row = 0;
            out_row = orow_end ? 0 : out_row + 1;
          end
        end
      end
    endfunction

    // One accepted pixel word against the oldest owed pixel
    function void check_pixel(logic [23:0] word, logic last);
      pix_t want, got;
      got = {last, word};
      if (owed_pixels.size() == 0) begin
        note_fault($sformatf("pixel %h last %b arrived with none owed", word, last));
      end else begin
        want = owed_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.last !== want.last)
          note_fault($sformatf("pixel r/g/b/last want %h/%h/%h/%b got %h/%h/%h/%b",
                               want.red, want.green, want.blue, want.last,
                               got.red, got.green, got.blue, got.last));
      end
    endfunction

    function void closing_check();
      if (owed_pixels.size() != 0)
        note_fault($sformatf("%0d pixels never arrived", owed_pixels.size()));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and shared state
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;       // red [7:0], green [15:8], blue [23:16]
  logic                  out_tlast;       // frame_end

  pixel_average_book     book;
  idle_mode_e            mode = IDLE_NONE;
  int                    hold_request = 0;
  int                    cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  box_average_downsampler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("box_average_downsampler_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stall decisions
  // --------------------------------------------------------------------------
  function automatic bit stall_now(bit sender_side);
    case (mode)
      IDLE_SENDER:   return sender_side && ($urandom_range(0, 99) < 63);
      IDLE_RECEIVER: return !sender_side && ($urandom_range(0, 99) < 63);
      IDLE_BOTH:     return $urandom_range(0, 99) < 7;
      default:       return 1'b0;
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off when asked for
  initial begin : pixel_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !stall_now(1'b0);
      end
    end
  end

  // Pixel words taken at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_pixel(out_tdata, out_tlast);
  end

  // --------------------------------------------------------------------------
  // Drivers; every task is entered and left at a falling edge
  // --------------------------------------------------------------------------
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(logic [12:0] scale_d, logic [12:0] width_d, logic [12:0] height_d);
    cfg_write(CFG_SCALE, scale_d);
    cfg_write(CFG_WIDTH, width_d);
    cfg_write(CFG_HEIGHT, height_d);
    if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, 13'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(logic [23:0] word);
    while (stall_now(1'b1)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.note_sample(word);
    @(negedge clk);
  endtask

  // Stop offering, wait for every owed pixel, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (!book.idle()) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Register encodings: out-of-range forms and junk above the field now and then
  // --------------------------------------------------------------------------
  function automatic logic [12:0] encode_scale(int unsigned s);
    logic [12:0] d;
    d = 13'($urandom());
    if (s == 1 && $urandom_range(0, 2) == 0) d[3:0] = 4'd0;
    else if (s == MAX_FACTOR && $urandom_range(0, 1) == 0)
      d[3:0] = 4'($urandom_range(MAX_FACTOR + 1, 15));
    else d[3:0] = 4'(s);
    return d;
  endfunction

  function automatic logic [12:0] encode_width(int unsigned w);
    logic [12:0] d;
    d = 13'($urandom());
    d[10:0] = (w == 1 && $urandom_range(0, 2) == 0) ? 11'd0 : 11'(w);
    return d;
  endfunction

  function automatic logic [12:0] encode_height(int unsigned h);
    return (h == 1 && $urandom_range(0, 2) == 0) ? 13'd0 : 13'(h);
  endfunction

  // Mostly random bytes, with saturated and empty samples mixed in
  function automatic logic [23:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 24'h000000;
    if (pick < 3) return 24'hFFFFFF;
    return 24'($urandom());
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned s, w, h, frames, frame_words, random_count, phase;
    book = new();
    random_count = 0;
    phase = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values: 1x1 blocks in a 1x1 image, every sample is a last pixel
    send_word(24'h000000);
    send_word(24'hFFFFFF);
    send_word(24'hAA7F01);
    send_word(24'h5580FE);
    drain();

    // 2x2 blocks, two columns; one block truncates 1019/4 down
    configure(13'd2, 13'd2, 13'd1);
    send_word(24'hFFFFFF);
    send_word(24'hFFFFFF);
    send_word(24'h000000);
    send_word(24'h010203);
    send_word(24'hFFFFFF);
    send_word(24'hFEFEFE);
    send_word(24'h000000);
    send_word(24'h000000);
    drain();

    // Zero in every register reads as one
    configure(13'd0, 13'd0, 13'd0);
    send_word(24'h123456);
    drain();

    // Scale dropped part way into a block: the sum overflows a byte and clips
    configure(13'd2, 13'd1, 13'd1);
    send_word(24'h808080);
    send_word(24'h808080);
    send_word(24'h808080);
    drain();
    configure(13'd1, 13'd1, 13'd1);
    send_word(24'h808080);
    drain();

    // Width beyond the limit, then cut back mid-row: column wraps at once
    configure(13'd1, 13'h1FFF, 13'd1);
    repeat (4) send_word(random_sample());
    drain();
    configure(13'd1, 13'd1, 13'd1);
    send_word(random_sample());
    drain();

    // Height beyond the limit, then cut back mid-frame
    configure(13'd1, 13'd1, 13'h1FFF);
    repeat (2) send_word(random_sample());
    drain();
    configure(13'd1, 13'd1, 13'd1);
    send_word(random_sample());
    drain();

    // Random whole frames, each phase under its own idling pattern
    while (random_count < RANDOM_ITEMS) begin
      if (phase == 3) begin
        s = 1;
        w = $urandom_range(2, 8);
        h = 4;
      end else if ($urandom_range(0, 9) < 3) begin
        s = $urandom_range(5, MAX_FACTOR);
        w = $urandom_range(1, 2);
        h = $urandom_range(1, 2);
      end else begin
        s = $urandom_range(1, 4);
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 4);
      end
      frame_words = s * s * w * h;
      frames = (phase == 3) ? 3 : 1 + $urandom_range(0, 200 / frame_words);
      if (frames > 4) frames = 4;
      configure(encode_scale(s), encode_width(w), encode_height(h));

      mode = idle_mode_e'(phase % 4);
      if (phase == 3) begin
        // receiver holds off while the sender keeps offering
        hold_request = LONG_HOLD;
      end
      repeat (frames * frame_words) begin
        send_word(random_sample());
        random_count++;
      end
      drain();
      phase++;
    end

    // Final settle already done by the last drain
    book.closing_check();
    if (book.faults == 0) $display("box_average_downsampler_tb OK");
    else $display("box_average_downsampler_tb NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/boxavg_pkg.sv
rtl/boxavg_ram.sv
rtl/boxavg_div.sv
rtl/box_average_downsampler.sv
test/box_average_downsampler_tb.sv
